// ----- rtl/core/sda_pkg.sv -----
// ----------------------------------------------------------------------------
// sda_pkg
// Shared types and codes for the swipe direction arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package sda_pkg;

   // event kind codes
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_TOUCH = 2'd1;
   localparam logic [1:0] KIND_DIR   = 2'd2;

   // direction codes
   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_LEAD_MARGIN  = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_LIMIT = 2'd1;
   localparam logic [1:0] CSR_IDLE_TIMEOUT = 2'd2;

   // register reset values
   localparam logic [7:0]  LEAD_MARGIN_RST  = 8'd3;
   localparam logic [7:0]  SAMPLE_LIMIT_RST = 8'd8;
   localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd0;

   // one input beat
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  direction;
      logic        pressed;
      logic [31:0] timestamp_ms;
   } item_type;

   // vote state
   typedef struct packed {
      logic [3:0][7:0] counts;
      logic [1:0]      chosen;
      logic            decided;
      logic            emitted;
      logic            awaiting;
   } vote_type;

endpackage

`default_nettype wire

// ----- rtl/core/swipe_direction_arbiter.sv -----
// ----------------------------------------------------------------------------
// swipe_direction_arbiter
// Votes on swipe direction and passes one direction press and its release per gesture; other events pass.
// ----------------------------------------------------------------------------
//
//   channel  ports                                        role
//   -------  -------------------------------------------  ---------------------
//   req      req_valid req_stall req_type req_direction   event beat in
//            req_pressed req_timestamp_ms
//   rsp      rsp_valid rsp_stall rsp_pass_event           one verdict per event
//   csr      csr_wr_en csr_index csr_wdata                register write
//
// one beat per cycle sustained while rsp_stall is low; rsp_valid rises once the
// beat has passed the input register and the vote update into the result register
// synchronous active-high reset clears the vote, the flags, the stored time
// and loads register defaults
// rsp_stall holds the result register; req_stall rises only when both the
// input and result registers are full and the result is not taken
`default_nettype none

module swipe_direction_arbiter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [1:0]  req_direction,
   input  wire logic        req_pressed,
   input  wire logic [31:0] req_timestamp_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_pass_event,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   // configuration registers
   logic [7:0]  lead_ff;
   logic [7:0]  limit_ff;
   logic [31:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff    <= sda_pkg::LEAD_MARGIN_RST;
         limit_ff   <= sda_pkg::SAMPLE_LIMIT_RST;
         timeout_ff <= sda_pkg::IDLE_TIMEOUT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            sda_pkg::CSR_LEAD_MARGIN:  lead_ff    <= csr_wdata[7:0];
            sda_pkg::CSR_SAMPLE_LIMIT: limit_ff   <= csr_wdata[7:0];
            sda_pkg::CSR_IDLE_TIMEOUT: timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic             in_vld_ff;
   sda_pkg::item_type item_ff;
   logic             out_vld_ff;
   logic             out_pass_ff;
   logic             advance;
   logic             out_free;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.kind         <= req_type;
         item_ff.direction    <= req_direction;
         item_ff.pressed      <= req_pressed;
         item_ff.timestamp_ms <= req_timestamp_ms;
      end
   end

   // vote state
   sda_pkg::vote_type vote_ff;
   sda_pkg::vote_type vote_in;
   logic [31:0]       last_ff;
   logic [31:0]       last_in;
   logic              pass_in;

   // vote update for the beat in the input register
   sda_pkg::vote_type base;
   sda_pkg::vote_type bumped;
   logic [31:0]       gap;
   logic              timed_out;
   logic [8:0]        vert;
   logic [8:0]        horiz;
   logic [9:0]        total;
   logic [8:0]        diff;
   logic              commit;
   logic [1:0]        pick;

   always_comb begin
      vote_in = vote_ff;
      last_in = last_ff;
      pass_in = 1'b1;

      // idle gap check, modulo 2^32
      gap       = item_ff.timestamp_ms - last_ff;
      timed_out = (timeout_ff != 32'd0) && (last_ff != 32'd0) && (gap > timeout_ff);

      base = vote_ff;
      if (timed_out) begin
         base = '0;
      end

      // count this press
      bumped = base;
      bumped.counts[item_ff.direction] = base.counts[item_ff.direction] + 8'd1;

      vert  = {1'b0, bumped.counts[sda_pkg::DIR_N]} + {1'b0, bumped.counts[sda_pkg::DIR_S]};
      horiz = {1'b0, bumped.counts[sda_pkg::DIR_E]} + {1'b0, bumped.counts[sda_pkg::DIR_W]};
      total = {1'b0, vert} + {1'b0, horiz};
      diff  = (vert > horiz) ? (vert - horiz) : (horiz - vert);
      commit = (diff >= {1'b0, lead_ff}) ||
               ((total >= {2'b00, limit_ff}) && (vert != horiz));

      // larger counter in the leading axis, ties to north or east
      if (vert > horiz) begin
         pick = (bumped.counts[sda_pkg::DIR_N] >= bumped.counts[sda_pkg::DIR_S]) ?
                sda_pkg::DIR_N : sda_pkg::DIR_S;
      end else begin
         pick = (bumped.counts[sda_pkg::DIR_E] >= bumped.counts[sda_pkg::DIR_W]) ?
                sda_pkg::DIR_E : sda_pkg::DIR_W;
      end

      case (item_ff.kind)
         sda_pkg::KIND_TOUCH: begin
            if (!item_ff.pressed) begin
               vote_in = '0;
            end
         end
         sda_pkg::KIND_DIR: begin
            last_in = item_ff.timestamp_ms;
            vote_in = base;
            if (!item_ff.pressed) begin
               // release of the committed direction
               if (base.awaiting && (item_ff.direction == base.chosen)) begin
                  vote_in.awaiting = 1'b0;
               end else begin
                  pass_in = 1'b0;
               end
            end else if (base.emitted) begin
               pass_in = 1'b0;
            end else begin
               vote_in = bumped;
               if (!base.decided) begin
                  if (commit) begin
                     vote_in.chosen  = pick;
                     vote_in.decided = 1'b1;
                  end
               end
               if (!vote_in.decided || (item_ff.direction != vote_in.chosen)) begin
                  pass_in = 1'b0;
               end else begin
                  vote_in.emitted  = 1'b1;
                  vote_in.awaiting = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_ff <= '0;
         last_ff <= 32'd0;
      end else if (advance) begin
         vote_ff <= vote_in;
         last_ff <= last_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pass_ff <= pass_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_pass_event = out_pass_ff;

   // checks
   a_await_needs_emit: assert property (@(posedge clock) disable iff (reset)
      vote_ff.awaiting |-> vote_ff.emitted)
      else $error("awaiting release without an emitted press");

   a_emit_needs_decision: assert property (@(posedge clock) disable iff (reset)
      vote_ff.emitted |-> vote_ff.decided)
      else $error("press emitted without a committed direction");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("input stalled while the pipeline can move");

   a_lift_clears_vote: assert property (@(posedge clock) disable iff (reset)
      (advance && (item_ff.kind == sda_pkg::KIND_TOUCH) && !item_ff.pressed)
      |=> (!vote_ff.decided && !vote_ff.awaiting && (vote_ff.counts == '0)))
      else $error("touch lift did not clear the vote");

endmodule

`default_nettype wire
